// ===== rtl/core/flprs_pkg.sv =====
// ----------------------------------------------------------------------------
// flprs_pkg: shared types and constants of the four-level request scheduler
// Queue sizing, level codes, payload structs and controller command struct.
// ----------------------------------------------------------------------------
package flprs_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int TAG_W       = 16;
   localparam int LEVEL_W     = 2;
   localparam int NUM_QUEUES  = 3;

   localparam logic [LEVEL_W-1:0] LVL_HIGHEST    = 2'd0;
   localparam logic [LEVEL_W-1:0] LVL_HIGH       = 2'd1;
   localparam logic [LEVEL_W-1:0] LVL_NORMAL     = 2'd2;
   localparam logic [LEVEL_W-1:0] LVL_BACKGROUND = 2'd3;

   localparam logic OP_SUBMIT = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [LEVEL_W-1:0] priority_level;
      logic [TAG_W-1:0]   request_tag;
      logic               handlers_done;
   } req_type;

   typedef struct packed {
      logic               cancel_issued;
      logic               request_ignored;
      logic               queue_overflow;
      logic               dispatch_valid;
      logic [TAG_W-1:0]   dispatch_tag;
      logic [LEVEL_W-1:0] active_level;
      logic               all_done;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;   // capture the accepted request
      logic exec;   // apply the request and load the result register
   } cmd_type;

endpackage

// ===== rtl/core/flprs_fifo.sv =====
// ----------------------------------------------------------------------------
// flprs_fifo: one tag queue of the scheduler
// Circular buffer with head pointer and fill count; head entry is read into
// a register every cycle. Clear resets head and count.
// ----------------------------------------------------------------------------
module flprs_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  logic                           pop,
   input  logic                           clear,
   input  logic [flprs_pkg::TAG_W-1:0]    push_tag,
   output logic [flprs_pkg::TAG_W-1:0]    head_tag,
   output logic                           empty,
   output logic                           full
);

   logic [flprs_pkg::TAG_W-1:0] queue_mem_ff [flprs_pkg::QUEUE_DEPTH];
   logic [flprs_pkg::TAG_W-1:0] head_tag_ff;
   logic [flprs_pkg::PTR_W-1:0] head_ff, head_in;
   logic [flprs_pkg::CNT_W-1:0] count_ff, count_in;
   logic [flprs_pkg::PTR_W:0]   tail_sum;
   logic [flprs_pkg::PTR_W-1:0] tail_ptr;
   logic                        do_push;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == flprs_pkg::CNT_W'(flprs_pkg::QUEUE_DEPTH));
   assign do_push = push && !full;
   assign head_tag = head_tag_ff;

   // head + count stays below twice the depth, so one subtract wraps it
   always_comb begin
      tail_sum = {1'b0, head_ff} + (flprs_pkg::PTR_W + 1)'(count_ff);
      if (tail_sum >= (flprs_pkg::PTR_W + 1)'(flprs_pkg::QUEUE_DEPTH)) begin
         tail_sum = tail_sum - (flprs_pkg::PTR_W + 1)'(flprs_pkg::QUEUE_DEPTH);
      end
      tail_ptr = tail_sum[flprs_pkg::PTR_W-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (clear) begin
         head_in  = '0;
         count_in = '0;
      end else if (pop && !empty) begin
         if (head_ff == flprs_pkg::PTR_W'(flprs_pkg::QUEUE_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + 1'b1;
         end
         count_in = count_ff - 1'b1;
      end else if (do_push) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push && !clear) begin
         queue_mem_ff[tail_ptr] <= push_tag;
      end
      head_tag_ff <= queue_mem_ff[head_ff];
   end

endmodule

// ===== rtl/core/flprs_datapath.sv =====
// ----------------------------------------------------------------------------
// flprs_datapath: request register, queues, level state and result register
// Applies one captured submit or tick when the controller commands it.
// ----------------------------------------------------------------------------
module flprs_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  flprs_pkg::cmd_type   cmd,
   input  flprs_pkg::req_type   req_data,
   output flprs_pkg::rsp_type   rsp_data
);

   flprs_pkg::req_type item_ff;
   flprs_pkg::rsp_type rsp_ff, rsp_in;

   logic [flprs_pkg::TAG_W-1:0]   bg_tag_ff, bg_tag_in;
   logic                          bg_valid_ff, bg_valid_in;
   logic [flprs_pkg::LEVEL_W-1:0] level_ff, level_in;
   logic                          done_ff, done_in;

   logic [flprs_pkg::NUM_QUEUES-1:0] push, pop, empty, full;
   logic                             clear_lower;
   logic [flprs_pkg::TAG_W-1:0]      head_tag [flprs_pkg::NUM_QUEUES];

   logic is_submit, is_tick, hi_active;
   logic [flprs_pkg::LEVEL_W-1:0] lvl;

   assign rsp_data = rsp_ff;

   for (genvar q = 0; q < flprs_pkg::NUM_QUEUES; q++) begin : g_queue
      flprs_fifo u_fifo (
         .clock    (clock),
         .reset    (reset),
         .push     (push[q]),
         .pop      (pop[q]),
         .clear    (clear_lower && (q != 0)),
         .push_tag (item_ff.request_tag),
         .head_tag (head_tag[q]),
         .empty    (empty[q]),
         .full     (full[q])
      );
   end

   always_comb begin
      is_submit = (item_ff.opcode == flprs_pkg::OP_SUBMIT);
      is_tick   = (item_ff.opcode == flprs_pkg::OP_TICK);
      lvl       = item_ff.priority_level;
      hi_active = (level_ff == flprs_pkg::LVL_HIGHEST);

      push        = '0;
      pop         = '0;
      clear_lower = 1'b0;
      bg_tag_in   = bg_tag_ff;
      bg_valid_in = bg_valid_ff;
      level_in    = level_ff;
      done_in     = done_ff;
      rsp_in      = '0;

      if (is_submit) begin
         case (lvl)
            flprs_pkg::LVL_HIGHEST: begin
               // preempts everything below it
               clear_lower           = cmd.exec;
               bg_tag_in             = '0;
               bg_valid_in           = 1'b0;
               push[0]               = cmd.exec;
               rsp_in.cancel_issued  = 1'b1;
               rsp_in.queue_overflow = full[0];
            end
            flprs_pkg::LVL_HIGH: begin
               if (hi_active) begin
                  rsp_in.request_ignored = 1'b1;
               end else begin
                  push[1]               = cmd.exec;
                  rsp_in.cancel_issued  = (level_ff != flprs_pkg::LVL_HIGH);
                  rsp_in.queue_overflow = full[1];
               end
            end
            flprs_pkg::LVL_NORMAL: begin
               if (hi_active) begin
                  rsp_in.request_ignored = 1'b1;
               end else begin
                  push[2]               = cmd.exec;
                  rsp_in.queue_overflow = full[2];
               end
            end
            default: begin
               if (hi_active) begin
                  rsp_in.request_ignored = 1'b1;
               end else begin
                  bg_tag_in   = item_ff.request_tag;
                  bg_valid_in = 1'b1;
               end
            end
         endcase
      end else if (is_tick) begin
         done_in = item_ff.handlers_done;
         if (item_ff.handlers_done) begin
            if (!empty[0]) begin
               pop[0]                = cmd.exec;
               rsp_in.dispatch_valid = 1'b1;
               rsp_in.dispatch_tag   = head_tag[0];
               level_in              = flprs_pkg::LVL_HIGHEST;
            end else if (!empty[1]) begin
               pop[1]                = cmd.exec;
               rsp_in.dispatch_valid = 1'b1;
               rsp_in.dispatch_tag   = head_tag[1];
               level_in              = flprs_pkg::LVL_HIGH;
            end else if (!empty[2]) begin
               pop[2]                = cmd.exec;
               rsp_in.dispatch_valid = 1'b1;
               rsp_in.dispatch_tag   = head_tag[2];
               level_in              = flprs_pkg::LVL_NORMAL;
            end else begin
               // background slot is kept after dispatch
               level_in              = flprs_pkg::LVL_BACKGROUND;
               rsp_in.dispatch_valid = bg_valid_ff;
               rsp_in.dispatch_tag   = bg_valid_ff ? bg_tag_ff : '0;
            end
         end
      end

      rsp_in.active_level = level_in;
      rsp_in.all_done     = done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_tag_ff   <= '0;
         bg_valid_ff <= 1'b0;
         level_ff    <= flprs_pkg::LVL_BACKGROUND;
         done_ff     <= 1'b1;
      end else if (cmd.exec) begin
         bg_tag_ff   <= bg_tag_in;
         bg_valid_ff <= bg_valid_in;
         level_ff    <= level_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ===== rtl/core/flprs_ctrl.sv =====
// ----------------------------------------------------------------------------
// flprs_ctrl: handshake controller of the scheduler
// Takes one request at a time, sequences its execution and owns rsp_valid.
// ----------------------------------------------------------------------------
module flprs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output flprs_pkg::cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   // result register can take a new value when empty or being drained
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/four_level_preemptive_request_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// four_level_preemptive_request_scheduler_core: strict-priority tag scheduler
// Flow: a transfer loads the request register, and the execute step then loads
// the result register, from which the result transfer is made. A new request
// is taken only after the previous one has executed (capture, then execute
// against the registered queue heads); a stalled result holds the execute step.
// Reset: queues empty, background slot empty, background level, done set.
// ----------------------------------------------------------------------------
module four_level_preemptive_request_scheduler_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  flprs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output flprs_pkg::rsp_type rsp_data
);

   flprs_pkg::cmd_type cmd;

   flprs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   flprs_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the four-level request scheduler core
// Drives submits and ticks in bursts with random gaps while the response side
// stalls on its own pattern. Every response is compared field by field against
// a cycle-free scheduler model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 1100;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_AT_ITEM   = 300;
   localparam int PAUSE_AT_ITEM  = 700;

   typedef enum int {GEN_MIX, GEN_FILL, GEN_STORM, GEN_DRAIN, GEN_NOISE} stim_mode_type;

   // -------------------------------------------------------------------------
   // Scheduler model and response checker
   // -------------------------------------------------------------------------
   class sched_scoreboard_type;
      logic [flprs_pkg::TAG_W-1:0]   lane_store [flprs_pkg::NUM_QUEUES][flprs_pkg::QUEUE_DEPTH];
      int unsigned                   lane_count [flprs_pkg::NUM_QUEUES];
      int unsigned                   lane_head  [flprs_pkg::NUM_QUEUES];
      logic [flprs_pkg::TAG_W-1:0]   bg_tag;
      logic                          bg_valid;
      logic [flprs_pkg::LEVEL_W-1:0] level_now;
      logic                          done_now;
      flprs_pkg::rsp_type            pending_outcomes [$];
      int                            mismatch_count;
      int                            request_count;
      int                            response_count;
      int                            dispatch_count;
      int                            overflow_count;
      int                            ignored_count;
      int                            cancel_count;

      function new();
         for (int i = 0; i < flprs_pkg::NUM_QUEUES; i++) begin
            lane_count[i] = 0;
            lane_head[i]  = 0;
         end
         bg_tag         = '0;
         bg_valid       = 1'b0;
         level_now      = flprs_pkg::LVL_BACKGROUND;
         done_now       = 1'b1;
         mismatch_count = 0;
         request_count  = 0;
         response_count = 0;
         dispatch_count = 0;
         overflow_count = 0;
         ignored_count  = 0;
         cancel_count   = 0;
      endfunction

      function int pending_count();
         return pending_outcomes.size();
      endfunction

      // returns 1 when the lane is full and the tag is dropped
      function logic push_tag(int lane, logic [flprs_pkg::TAG_W-1:0] tag);
         if (lane_count[lane] >= flprs_pkg::QUEUE_DEPTH) return 1'b1;
         lane_store[lane][(lane_head[lane] + lane_count[lane]) % flprs_pkg::QUEUE_DEPTH] = tag;
         lane_count[lane]++;
         return 1'b0;
      endfunction

      function void flush_lane(int lane);
         lane_count[lane] = 0;
         lane_head[lane]  = 0;
      endfunction

      // works out the scheduler outcome of one accepted transfer
      function void schedule_request(flprs_pkg::req_type item);
         flprs_pkg::rsp_type outcome;
         int                 lane;
         outcome = '0;
         request_count++;
         if (item.opcode == flprs_pkg::OP_SUBMIT) begin
            if (item.priority_level == flprs_pkg::LVL_HIGHEST) begin
               // preemption: drop all lower work, highest lane itself survives
               flush_lane(flprs_pkg::LVL_HIGH);
               flush_lane(flprs_pkg::LVL_NORMAL);
               bg_tag                 = '0;
               bg_valid               = 1'b0;
               outcome.cancel_issued  = 1'b1;
               outcome.queue_overflow = push_tag(flprs_pkg::LVL_HIGHEST, item.request_tag);
            end else if (level_now == flprs_pkg::LVL_HIGHEST) begin
               outcome.request_ignored = 1'b1;
            end else if (item.priority_level == flprs_pkg::LVL_HIGH) begin
               outcome.cancel_issued  = (level_now != flprs_pkg::LVL_HIGH);
               outcome.queue_overflow = push_tag(flprs_pkg::LVL_HIGH, item.request_tag);
            end else if (item.priority_level == flprs_pkg::LVL_NORMAL) begin
               outcome.queue_overflow = push_tag(flprs_pkg::LVL_NORMAL, item.request_tag);
            end else begin
               bg_tag   = item.request_tag;
               bg_valid = 1'b1;
            end
         end else begin
            done_now = item.handlers_done;
            if (item.handlers_done) begin
               lane = flprs_pkg::NUM_QUEUES;
               for (int i = flprs_pkg::NUM_QUEUES - 1; i >= 0; i--)
                  if (lane_count[i] != 0) lane = i;
               if (lane < flprs_pkg::NUM_QUEUES) begin
                  outcome.dispatch_valid = 1'b1;
                  outcome.dispatch_tag   = lane_store[lane][lane_head[lane]];
                  lane_head[lane]        = (lane_head[lane] + 1) % flprs_pkg::QUEUE_DEPTH;
                  lane_count[lane]--;
                  level_now              = lane[flprs_pkg::LEVEL_W-1:0];
               end else begin
                  // background slot is dispatched but kept
                  level_now = flprs_pkg::LVL_BACKGROUND;
                  if (bg_valid) begin
                     outcome.dispatch_valid = 1'b1;
                     outcome.dispatch_tag   = bg_tag;
                  end
               end
            end
         end
         outcome.active_level = level_now;
         outcome.all_done     = done_now;
         dispatch_count += outcome.dispatch_valid;
         overflow_count += outcome.queue_overflow;
         ignored_count  += outcome.request_ignored;
         cancel_count   += outcome.cancel_issued;
         pending_outcomes.insert(pending_outcomes.size(), outcome);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            mismatch_count++;
            $display("%0t: mismatch on %s, expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      function void check_response(flprs_pkg::rsp_type actual);
         flprs_pkg::rsp_type want;
         response_count++;
         if (pending_outcomes.size() == 0) begin
            mismatch_count++;
            $display("%0t: response with none expected, expected none, actual %h",
                     $time, actual);
            return;
         end
         want = pending_outcomes[0];
         pending_outcomes.delete(0);
         compare_field("cancel_issued",   want.cancel_issued,   actual.cancel_issued);
         compare_field("request_ignored", want.request_ignored, actual.request_ignored);
         compare_field("queue_overflow",  want.queue_overflow,  actual.queue_overflow);
         compare_field("dispatch_valid",  want.dispatch_valid,  actual.dispatch_valid);
         compare_field("dispatch_tag",    want.dispatch_tag,    actual.dispatch_tag);
         compare_field("active_level",    want.active_level,    actual.active_level);
         compare_field("all_done",        want.all_done,        actual.all_done);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals, clock, DUT
   // -------------------------------------------------------------------------
   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   flprs_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   flprs_pkg::rsp_type rsp_data;

   sched_scoreboard_type sb;
   bit                   hold_off_req;
   int                   hold_offs_done;
   int                   idle_cycles = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   four_level_preemptive_request_scheduler_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // -------------------------------------------------------------------------
   // Item builders
   // -------------------------------------------------------------------------
   function automatic flprs_pkg::req_type submit_item(logic [flprs_pkg::LEVEL_W-1:0] lvl,
                                                      logic [flprs_pkg::TAG_W-1:0] tag);
      flprs_pkg::req_type item;
      item.opcode         = flprs_pkg::OP_SUBMIT;
      item.priority_level = lvl;
      item.request_tag    = tag;
      item.handlers_done  = $urandom_range(0, 1);
      return item;
   endfunction

   function automatic flprs_pkg::req_type tick_item(logic done);
      flprs_pkg::req_type item;
      item.opcode         = flprs_pkg::OP_TICK;
      item.priority_level = $urandom_range(0, 3);
      item.request_tag    = $urandom_range(0, 16'hFFFF);
      item.handlers_done  = done;
      return item;
   endfunction

   function automatic stim_mode_type pick_mode();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return GEN_MIX;
      if (roll < 60) return GEN_FILL;
      if (roll < 70) return GEN_STORM;
      if (roll < 90) return GEN_DRAIN;
      return GEN_NOISE;
   endfunction

   function automatic flprs_pkg::req_type make_item(stim_mode_type mode);
      flprs_pkg::req_type item;
      int                 roll;
      item = submit_item($urandom_range(0, 3), $urandom_range(0, 16'hFFFF));
      roll = $urandom_range(0, 99);
      case (mode)
         GEN_MIX: begin
            if (roll < 45) item = tick_item($urandom_range(0, 99) < 85);
         end
         GEN_FILL: begin
            // mostly high/normal pushes so the lanes overflow
            if (roll < 8)       item = tick_item(1'b1);
            else if (roll < 11) item.priority_level = flprs_pkg::LVL_HIGHEST;
            else if (roll < 95) item.priority_level = $urandom_range(1, 2);
            else                item.priority_level = flprs_pkg::LVL_BACKGROUND;
         end
         GEN_STORM: begin
            if (roll < 10)      item = tick_item($urandom_range(0, 99) < 90);
            else if (roll < 75) item.priority_level = flprs_pkg::LVL_HIGHEST;
         end
         GEN_DRAIN: begin
            if (roll < 90) item = tick_item($urandom_range(0, 99) < 90);
         end
         default: begin
            if (roll < 50) item = tick_item($urandom_range(0, 1));
         end
      endcase
      return item;
   endfunction

   // -------------------------------------------------------------------------
   // Driver tasks
   // -------------------------------------------------------------------------
   task automatic send_item(input flprs_pkg::req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_gap(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Response-side stall pattern
   // -------------------------------------------------------------------------
   initial begin : rsp_pacer
      int span;
      int kind;
      rsp_stall      = 1'b0;
      hold_offs_done = 0;
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_offs_done++;
            span = HOLD_CYCLES;
            kind = 3;
         end else begin
            span = $urandom_range(5, 60);
            kind = $urandom_range(0, 2);
         end
         for (int i = 0; i < span; i++) begin
            @(posedge clock);
            case (kind)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 99) < 35);
               2:       rsp_stall <= (i % 3 == 0);
               default: rsp_stall <= 1'b1;
            endcase
         end
      end
   end

   // -------------------------------------------------------------------------
   // Monitor: note accepted requests, check accepted responses, watchdog
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.schedule_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d responses outstanding",
                     $time, sb.pending_count());
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int            sent;
      int            burst;
      stim_mode_type mode;
      sb           = new();
      hold_off_req = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset state, background slot, preemption, ignore, overflow
      send_item(tick_item(1'b0));
      send_item(tick_item(1'b1));
      send_item(submit_item(flprs_pkg::LVL_BACKGROUND, 16'hFFFF));
      send_item(tick_item(1'b1));
      send_item(tick_item(1'b1));
      send_item(submit_item(flprs_pkg::LVL_NORMAL, 16'h0000));
      send_item(submit_item(flprs_pkg::LVL_HIGH, 16'h1234));
      send_item(tick_item(1'b1));
      send_item(submit_item(flprs_pkg::LVL_HIGH, 16'h8001));
      send_item(submit_item(flprs_pkg::LVL_HIGHEST, 16'hA5A5));
      send_item(tick_item(1'b1));
      send_item(submit_item(flprs_pkg::LVL_NORMAL, 16'h5A5A));
      send_item(submit_item(flprs_pkg::LVL_HIGH, 16'h7FFF));
      send_item(submit_item(flprs_pkg::LVL_BACKGROUND, 16'h0001));
      // highest while highest active is taken; ninth push overflows
      for (int i = 0; i <= flprs_pkg::QUEUE_DEPTH; i++)
         send_item(submit_item(flprs_pkg::LVL_HIGHEST, 16'hF000 | i));
      send_item(tick_item(1'b1));
      idle_gap(3);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 40);
         mode  = pick_mode();
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            send_item(make_item(mode));
            sent++;
            if (sent == HOLD_AT_ITEM) hold_off_req = 1'b1;
            if (sent == PAUSE_AT_ITEM) wait_drained();
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 20));
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Summary: %0d transfers in, %0d responses checked, %0d long hold-offs",
               sb.request_count, sb.response_count, hold_offs_done);
      $display("         %0d dispatches, %0d cancels, %0d overflows, %0d ignored submits",
               sb.dispatch_count, sb.cancel_count, sb.overflow_count, sb.ignored_count);
      if (sb.mismatch_count == 0 && sb.pending_count() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
